FILE: hw/rtl/vtr_pkg.sv
// shared types, constants and codes of the video timestamp retimer
package vtr_pkg;

    // stamp and field widths
    localparam int StampW   = 64;
    localparam int FdW      = 30;
    localparam int DeltaW   = 32;
    localparam int DriftW   = 33;
    localparam int CountW   = 32;
    localparam int CorrW    = 2;
    localparam int SDataW   = 136;
    localparam int MDataW   = 136;
    localparam int ApbAddrW = 3;
    localparam int ApbDataW = 32;

    // largest valid stamp
    localparam logic [StampW-1:0] StampMax = 64'hFFFF_FFFF_FFFF_FFFE;

    // register reset value and register index
    localparam logic [FdW-1:0] FdReset = 30'd33333333;
    localparam logic [0:0] RegFrameDuration = 1'b0;

    // queue between classifier and retimer
    localparam int QDepth = 2;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    // request kinds handed to the retimer
    localparam logic [1:0] KindReset = 2'd0;
    localparam logic [1:0] KindPass  = 2'd1;
    localparam logic [1:0] KindRt    = 2'd2;
    localparam logic [1:0] KindAdd   = 2'd3;

    // classified request
    typedef struct packed {
        logic [1:0]        kind;
        logic [DeltaW-1:0] step;       // amount added to the last output stamp
        logic              pre_corr;   // delta or synthetic correction already taken
        logic [StampW-1:0] rt;         // running time, or pass-through stamp
        logic [StampW-1:0] rt_hi;      // saturated running time plus drift window
        logic [StampW-1:0] rt_lo;      // running time minus drift window
        logic              rt_lo_ok;   // running time not below the drift window
        logic              rt_ones;    // running time all ones
        logic              set_dur;
    } req_t;

    // saturating stamp add
    function automatic logic [StampW-1:0] sat_add(input logic [StampW-1:0] a,
                                                  input logic [StampW-1:0] b);
        logic [StampW:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum > {1'b0, StampMax}) begin
            return StampMax;
        end
        return sum[StampW-1:0];
    endfunction

endpackage

FILE: hw/rtl/vtr_front.sv
// request classifier: timeline flags, source delta check, drift window bounds
module vtr_front
    import vtr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [FdW-1:0]    frame_duration,
    input  logic              take,
    input  logic              action,
    input  logic [StampW-1:0] running_time,
    input  logic              running_time_valid,
    input  logic [StampW-1:0] source_pts,
    input  logic              source_pts_valid,
    input  logic              duration_valid,
    output req_t              req
);

    logic              anchor_valid_reg, anchor_valid_next;
    logic              history_valid_reg, history_valid_next;
    logic              last_known_reg, last_known_next;
    logic              syn_known_reg, syn_known_next;
    logic [StampW-1:0] last_src_reg, last_src_next;
    logic [FdW-1:0]    syn_fd_reg, syn_fd_next;

    logic [StampW-1:0] delta;
    logic [DeltaW-1:0] fd3;
    logic [DriftW-1:0] drift;
    logic              use_delta;
    logic              delta_bad;
    logic              passing;

    // frame duration multiples by shift and add
    assign fd3   = {2'b00, frame_duration} + {1'b0, frame_duration, 1'b0};
    assign drift = {2'b00, frame_duration, 1'b0} + {1'b0, frame_duration, 2'b00};

    // source delta and its plausibility window
    assign delta     = source_pts - last_src_reg;
    assign use_delta = source_pts_valid && history_valid_reg && last_known_reg
                       && (source_pts > last_src_reg);
    assign delta_bad = (delta < {35'd0, frame_duration[FdW-1:1]})
                       || (delta > {32'd0, fd3});
    assign passing   = !running_time_valid || (frame_duration == '0);

    // classify
    always_comb begin
        req          = '0;
        req.set_dur  = !duration_valid;
        req.rt       = running_time;
        req.rt_hi    = sat_add(running_time, {31'd0, drift});
        req.rt_lo    = running_time - {31'd0, drift};
        req.rt_lo_ok = running_time >= {31'd0, drift};
        req.rt_ones  = &running_time;
        if (action) begin
            req.kind = KindReset;
        end else if (passing) begin
            req.kind = KindPass;
            req.rt   = source_pts_valid ? source_pts : '0;
        end else if (!anchor_valid_reg) begin
            req.kind = KindRt;
        end else if (use_delta) begin
            req.kind     = KindAdd;
            req.step     = delta_bad ? {2'b00, frame_duration} : delta[DeltaW-1:0];
            req.pre_corr = delta_bad;
        end else if (syn_known_reg) begin
            // synthetic stamp steps by the duration in force at the last retimed frame
            req.kind     = KindAdd;
            req.step     = {2'b00, syn_fd_reg};
            req.pre_corr = source_pts_valid && history_valid_reg;
        end else begin
            req.kind = KindRt;
        end
    end

    // timeline flag update
    always_comb begin
        anchor_valid_next  = anchor_valid_reg;
        history_valid_next = history_valid_reg;
        last_known_next    = last_known_reg;
        syn_known_next     = syn_known_reg;
        last_src_next      = last_src_reg;
        syn_fd_next        = syn_fd_reg;
        if (take) begin
            if (action) begin
                anchor_valid_next  = 1'b0;
                history_valid_next = 1'b0;
                last_known_next    = 1'b0;
                syn_known_next     = 1'b0;
            end else if (!passing) begin
                anchor_valid_next  = 1'b1;
                history_valid_next = 1'b1;
                last_known_next    = source_pts_valid;
                syn_known_next     = 1'b1;
                last_src_next      = source_pts_valid ? source_pts : '0;
                syn_fd_next        = frame_duration;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            anchor_valid_reg  <= 1'b0;
            history_valid_reg <= 1'b0;
            last_known_reg    <= 1'b0;
            syn_known_reg     <= 1'b0;
            last_src_reg      <= '0;
            syn_fd_reg        <= '0;
        end else begin
            anchor_valid_reg  <= anchor_valid_next;
            history_valid_reg <= history_valid_next;
            last_known_reg    <= last_known_next;
            syn_known_reg     <= syn_known_next;
            last_src_reg      <= last_src_next;
            syn_fd_reg        <= syn_fd_next;
        end
    end

endmodule

FILE: hw/rtl/vtr_queue.sv
// short request queue between classifier and retimer
module vtr_queue
    import vtr_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  req_t push_req,
    output logic full,
    input  logic pop,
    output logic avail,
    output req_t pop_req
);

    req_t             slot_reg [QDepth];
    logic [QPtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCntW-1:0] count_reg, count_next;

    assign full    = (count_reg == QCntW'(QDepth));
    assign avail   = (count_reg != '0);
    assign pop_req = slot_reg[rd_ptr_reg];

    // pointer and fill update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

FILE: hw/rtl/vtr_back.sv
// retimer: output stamp, drift re-anchor, counters and output register
module vtr_back
    import vtr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              avail,
    input  req_t              req,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [MDataW-1:0] m_tdata
);

    logic [StampW-1:0] last_out_reg, last_out_next;
    logic [CountW-1:0] corr_cnt_reg, corr_cnt_next;
    logic [CountW-1:0] frame_cnt_reg, frame_cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic [MDataW-1:0] out_data_reg, out_data_next;

    logic [StampW-1:0] cand;
    logic [StampW-1:0] outp;
    logic              fail;
    logic [CorrW-1:0]  corr;

    assign pop = avail && (!out_valid_reg || m_tready);

    // candidate stamp and drift window check
    assign cand = (req.kind == KindAdd) ? sat_add(last_out_reg, {32'd0, req.step})
                                        : req.rt;
    assign fail = (cand > req.rt_hi) || req.rt_ones || (req.rt_lo_ok && (cand < req.rt_lo));
    assign outp = fail ? req.rt : cand;
    assign corr = {1'b0, req.pre_corr} + {1'b0, fail};

    // state and result
    always_comb begin
        last_out_next  = last_out_reg;
        corr_cnt_next  = corr_cnt_reg;
        frame_cnt_next = frame_cnt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        if (pop) begin
            out_valid_next = 1'b1;
            unique case (req.kind)
                KindReset: begin
                    out_data_next = {4'd0, frame_cnt_reg, corr_cnt_reg, 2'd0, 1'b0, 1'b1,
                                     {StampW{1'b0}}};
                end
                KindPass: begin
                    out_data_next = {4'd0, frame_cnt_reg, corr_cnt_reg, 2'd0, 1'b0, 1'b1,
                                     req.rt};
                end
                KindRt, KindAdd: begin
                    last_out_next  = outp;
                    corr_cnt_next  = corr_cnt_reg + {30'd0, corr};
                    frame_cnt_next = frame_cnt_reg + 1'b1;
                    out_data_next  = {4'd0, frame_cnt_next, corr_cnt_next, corr, req.set_dur,
                                      1'b0, outp};
                end
                default: begin
                    out_data_next = out_data_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_out_reg  <= '0;
            corr_cnt_reg  <= '0;
            frame_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            last_out_reg  <= last_out_next;
            corr_cnt_reg  <= corr_cnt_next;
            frame_cnt_reg <= frame_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: hw/rtl/video_timestamp_retimer.sv
// top level of the video timestamp retimer with its register port
//
//  port group   dir   contents
//  s_axis       in    frame or anchor-reset request, action in tuser
//  m_axis       out   retimed stamp, flags and counters, one per request
//  apb          in    frame_duration register at byte address 0
//
// one request per cycle while the result side takes results; a request's result is
// registered in the cycle after the request leaves the two-entry queue.
// the retimer loop (last output stamp to next candidate stamp) sets the rate.
// reset is synchronous and active low; the register returns to 33333333 ns.
// the queue absorbs output stalls; s_tready drops only while it is full.
module video_timestamp_retimer
    import vtr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // input requests
    input  logic                s_tvalid,
    output logic                s_tready,
    // [63:0] running_time, [64] running_time_valid, [128:65] source_pts,
    // [129] source_pts_valid, [130] duration_valid, [135:131] zero
    input  logic [SDataW-1:0]   s_tdata,
    // [0] action
    input  logic                s_tuser,
    // results
    output logic                m_tvalid,
    input  logic                m_tready,
    // [63:0] out_pts, [64] passed_through, [65] set_duration,
    // [67:66] corrections_this_frame, [99:68] correction_total,
    // [131:100] frame_total, [135:132] zero
    output logic [MDataW-1:0]   m_tdata,
    // register port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ApbAddrW-1:0] paddr,
    input  logic [ApbDataW-1:0] pwdata,
    output logic [ApbDataW-1:0] prdata,
    output logic                pready
);

    logic [FdW-1:0] fd_reg, fd_next;
    logic           take;
    logic           q_full;
    logic           q_avail;
    logic           q_pop;
    req_t           front_req;
    req_t           back_req;

    // register port
    assign pready = 1'b1;
    assign prdata = (paddr[ApbAddrW-1:2] == RegFrameDuration) ? {2'b00, fd_reg} : '0;

    always_comb begin
        fd_next = fd_reg;
        if (psel && penable && pwrite && (paddr[ApbAddrW-1:2] == RegFrameDuration)) begin
            fd_next = pwdata[FdW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fd_reg <= FdReset;
        end else begin
            fd_reg <= fd_next;
        end
    end

    // accept into the queue
    assign s_tready = !q_full;
    assign take     = s_tvalid && !q_full;

    vtr_front u_front (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .frame_duration     (fd_reg),
        .take               (take),
        .action             (s_tuser),
        .running_time       (s_tdata[63:0]),
        .running_time_valid (s_tdata[64]),
        .source_pts         (s_tdata[128:65]),
        .source_pts_valid   (s_tdata[129]),
        .duration_valid     (s_tdata[130]),
        .req                (front_req)
    );

    vtr_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (take),
        .push_req (front_req),
        .full     (q_full),
        .pop      (q_pop),
        .avail    (q_avail),
        .pop_req  (back_req)
    );

    vtr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .avail    (q_avail),
        .req      (back_req),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: bench/tb.sv
// self-checking bench for the video timestamp retimer: stream requests, register writes, checks
`timescale 1ns / 1ps

module tb;
    import vtr_pkg::*;

    // request kinds carried in s_tuser
    localparam bit ActFrame       = 1'b0;
    localparam bit ActAnchorReset = 1'b1;

    // timing rules of the retimer
    localparam int MinDeltaDiv    = 2;
    localparam int MaxDeltaFrames = 3;
    localparam int MaxDriftFrames = 6;

    // run control
    localparam int CycleLimit     = 1000000;
    localparam int LongHoldCycles = 300;
    localparam int DrainCycles    = 8;
    localparam int PhaseItems     = 265;
    localparam logic [ApbAddrW-1:0] FrameDurAddr = ApbAddrW'(4 * int'(RegFrameDuration));

    // one request as offered on the input stream
    typedef struct packed {
        bit        action;
        bit [63:0] rt;
        bit        rt_ok;
        bit [63:0] pts;
        bit        pts_ok;
        bit        dur_ok;
    } frame_req_t;

    // one retimed result
    typedef struct packed {
        bit [63:0] out_pts;
        bit        passed;
        bit        set_dur;
        bit [1:0]  corr;
        bit [31:0] corr_total;
        bit [31:0] frame_total;
    } stamp_res_t;

    // predicts retimed stamps and checks them in order
    class stamp_scoreboard;
        bit [29:0]  frame_ns;
        bit         anchored;
        bit         history_ok;
        bit [63:0]  prev_src;
        bit         prev_src_known;
        bit [63:0]  prev_out;
        bit [63:0]  syn_next;
        bit         syn_known;
        bit [31:0]  corr_count;
        bit [31:0]  frame_count;
        stamp_res_t expected_stamps[$];
        int         errors;

        function new();
            frame_ns       = FdReset;
            anchored       = 1'b0;
            history_ok     = 1'b0;
            prev_src       = '0;
            prev_src_known = 1'b0;
            prev_out       = '0;
            syn_next       = '0;
            syn_known      = 1'b0;
            corr_count     = '0;
            frame_count    = '0;
            errors         = 0;
        endfunction

        // stamp sum clamped at the largest valid stamp
        function bit [63:0] clamp_sum(bit [63:0] a, bit [63:0] b);
            bit [64:0] total;
            total = 65'(a) + 65'(b);
            return (total > 65'(StampMax)) ? StampMax : total[63:0];
        endfunction

        // work out the result of one accepted request
        function void predict_stamp(frame_req_t r);
            stamp_res_t e;
            bit [63:0]  fd;
            bit [63:0]  outp;
            bit [63:0]  delta;
            bit [63:0]  drift;
            bit [1:0]   corr;
            fd   = 64'(frame_ns);
            e    = '0;
            corr = '0;
            if (r.action == ActAnchorReset) begin
                anchored       = 1'b0;
                history_ok     = 1'b0;
                prev_src_known = 1'b0;
                syn_known      = 1'b0;
                e.passed       = 1'b1;
            end else if (!r.rt_ok || fd == 0) begin
                e.out_pts = r.pts_ok ? r.pts : 64'd0;
                e.passed  = 1'b1;
            end else begin
                outp = r.rt;
                if (!anchored) begin
                    anchored   = 1'b1;
                    history_ok = 1'b1;
                end else if (r.pts_ok && history_ok && prev_src_known && r.pts > prev_src) begin
                    delta = r.pts - prev_src;
                    if (delta < fd / MinDeltaDiv || delta > fd * MaxDeltaFrames) begin
                        delta = fd;
                        corr++;
                    end
                    outp = clamp_sum(prev_out, delta);
                end else if (syn_known) begin
                    outp = syn_next;
                    if (r.pts_ok && history_ok) corr++;
                end
                // pull back to running time when too far off
                drift = fd * MaxDriftFrames;
                if (clamp_sum(outp, drift) < r.rt || outp > clamp_sum(r.rt, drift)) begin
                    outp = r.rt;
                    corr++;
                end
                prev_src       = r.pts_ok ? r.pts : 64'd0;
                prev_src_known = r.pts_ok;
                prev_out       = outp;
                syn_next       = clamp_sum(outp, fd);
                syn_known      = 1'b1;
                history_ok     = 1'b1;
                corr_count     = corr_count + 32'(corr);
                frame_count    = frame_count + 32'd1;
                e.out_pts      = outp;
                e.set_dur      = !r.dur_ok;
                e.corr         = corr;
            end
            e.corr_total  = corr_count;
            e.frame_total = frame_count;
            expected_stamps.push_back(e);
        endfunction

        function void compare_field(string name, bit [63:0] exp_v, bit [63:0] act_v);
            if (exp_v != act_v) begin
                $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        // compare one result with the oldest prediction
        function void check_stamp(stamp_res_t got);
            stamp_res_t e;
            if (expected_stamps.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h", $time, got);
                errors++;
                return;
            end
            e = expected_stamps.pop_front();
            compare_field("out_pts", e.out_pts, got.out_pts);
            compare_field("passed_through", 64'(e.passed), 64'(got.passed));
            compare_field("set_duration", 64'(e.set_dur), 64'(got.set_dur));
            compare_field("corrections_this_frame", 64'(e.corr), 64'(got.corr));
            compare_field("correction_total", 64'(e.corr_total), 64'(got.corr_total));
            compare_field("frame_total", 64'(e.frame_total), 64'(got.frame_total));
        endfunction
    endclass

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [SDataW-1:0]   s_tdata = '0;
    logic                s_tuser = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [MDataW-1:0]   m_tdata;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ApbAddrW-1:0] paddr = '0;
    logic [ApbDataW-1:0] pwdata = '0;
    logic [ApbDataW-1:0] prdata;
    logic                pready;

    stamp_scoreboard sb = new();

    // stimulus timeline and idling control
    bit [63:0] tl_rt;
    bit [63:0] tl_pts;
    bit        tx_no_gaps;
    bit        hold_req;
    int        hold_left;
    int        run_left;
    bit        run_ready;
    int        cycle_count;

    video_timestamp_retimer u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("Verification failed");
            $finish;
        end
    end

    // result side: check accepted results, random stalls, one long hold on request
    always @(posedge aclk) begin
        if (m_tvalid === 1'b1 && m_tready) begin
            sb.check_stamp({m_tdata[63:0], m_tdata[64], m_tdata[65], m_tdata[67:66],
                            m_tdata[99:68], m_tdata[131:100]});
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = LongHoldCycles;
            m_tready <= 1'b0;
        end else begin
            if (run_left == 0) begin
                run_ready = ($urandom_range(99, 0) < 65);
                run_left  = ($urandom_range(9, 0) == 0) ? $urandom_range(60, 15)
                                                         : $urandom_range(4, 1);
            end
            run_left--;
            m_tready <= run_ready;
        end
    end

    function automatic frame_req_t mk(bit action, bit [63:0] rt, bit rt_ok,
                                      bit [63:0] pts, bit pts_ok, bit dur_ok);
        frame_req_t r;
        r.action = action;
        r.rt     = rt;
        r.rt_ok  = rt_ok;
        r.pts    = pts;
        r.pts_ok = pts_ok;
        r.dur_ok = dur_ok;
        return r;
    endfunction

    // random stamp with the extremes mixed in
    function automatic bit [63:0] rand_stamp();
        int p;
        p = $urandom_range(99, 0);
        if (p < 10) return '1;
        if (p < 20) return '0;
        if (p < 30) return StampMax;
        return {$urandom, $urandom};
    endfunction

    // next random request: mostly a steady frame stream, some noise and anchor resets
    function automatic frame_req_t next_frame();
        bit [63:0] fd;
        int        p;
        fd = 64'(sb.frame_ns);
        p  = $urandom_range(99, 0);
        if (p < 4) begin
            return mk(ActAnchorReset, rand_stamp(), 1'($urandom), rand_stamp(),
                      1'($urandom), 1'($urandom));
        end
        if (p < 12) begin
            return mk(ActFrame, rand_stamp(), 1'($urandom), rand_stamp(),
                      1'($urandom), 1'($urandom));
        end
        // running time advance
        p = $urandom_range(99, 0);
        if (p < 80) tl_rt += fd;
        else if (p < 92) tl_rt += 64'($urandom_range(32'(fd * 2), 0));
        else if (p < 96) tl_rt += fd * 64'($urandom_range(20, 7));
        else tl_rt -= fd * 64'($urandom_range(20, 7));
        // source stamp advance
        p = $urandom_range(99, 0);
        if (p < 50) tl_pts += 64'($urandom_range(32'(fd * 5 / 4), 32'(fd * 3 / 4)));
        else if (p < 70) tl_pts += 64'($urandom_range(32'(fd * MaxDeltaFrames), 32'(fd / 2)));
        else if (p < 78) tl_pts += 64'($urandom_range(32'(fd / 2), 0));
        else if (p < 84) tl_pts += fd * MaxDeltaFrames + 64'($urandom_range(32'(fd), 1));
        else if (p < 87) tl_pts += fd * 64'($urandom_range(100, 4));
        else if (p < 94) tl_pts -= 64'($urandom_range(32'(fd), 0));
        else tl_pts = rand_stamp();
        return mk(ActFrame, tl_rt, $urandom_range(99, 0) < 95, tl_pts,
                  $urandom_range(99, 0) < 90, 1'($urandom));
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(99, 0);
        if (tx_no_gaps || p < 45) return 0;
        if (p < 93) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // offer one request, wait for its handshake, then an optional gap
    task automatic send_frame(input frame_req_t r);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= r.action;
        s_tdata  <= {5'b0, r.dur_ok, r.pts_ok, r.pts, r.rt_ok, r.rt};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.predict_stamp(r);
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // wait until every predicted result has come back, then let the block settle
    task automatic wait_drained();
        while (sb.expected_stamps.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
    endtask

    // register write: setup then access
    task automatic write_frame_ns(input bit [29:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= FrameDurAddr;
        pwdata  <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.frame_ns = value;
    endtask

    // fixed sequence over the special cases at the reset frame duration
    task automatic run_directed();
        bit [63:0] f;
        f = 64'(FdReset);
        send_frame(mk(ActFrame, 64'd0, 1'b0, '1, 1'b1, 1'b1));
        send_frame(mk(ActFrame, '1, 1'b0, 64'd0, 1'b0, 1'b0));
        send_frame(mk(ActFrame, 64'd1000, 1'b1, 64'd5000, 1'b1, 1'b0));
        send_frame(mk(ActFrame, 1000 + f, 1'b1, 5000 + f, 1'b1, 1'b1));
        send_frame(mk(ActFrame, 1000 + 2 * f, 1'b1, 5000 + f + 1, 1'b1, 1'b1));
        send_frame(mk(ActFrame, 1000 + 3 * f, 1'b1, 5000 + 5 * f, 1'b1, 1'b1));
        send_frame(mk(ActFrame, 1000 + 4 * f, 1'b1, 5000 + 5 * f, 1'b1, 1'b1));
        send_frame(mk(ActFrame, 1000 + 5 * f, 1'b1, 5000 + 4 * f, 1'b1, 1'b1));
        send_frame(mk(ActFrame, 1000 + 6 * f, 1'b1, 64'd0, 1'b0, 1'b0));
        send_frame(mk(ActFrame, 1000 + 20 * f, 1'b1, 5000 + 6 * f, 1'b1, 1'b1));
        send_frame(mk(ActFrame, 1000 + 40 * f, 1'b1, 5000 + 16 * f, 1'b1, 1'b1));
        send_frame(mk(ActFrame, 64'd1000, 1'b1, 5000 + 17 * f, 1'b1, 1'b1));
        // anchor reset with every field set
        send_frame(mk(ActAnchorReset, '1, 1'b1, '1, 1'b1, 1'b1));
        // saturation near the top of the stamp range
        send_frame(mk(ActFrame, StampMax - 5, 1'b1, 64'd100, 1'b1, 1'b0));
        send_frame(mk(ActFrame, '1, 1'b1, 100 + f, 1'b1, 1'b1));
        send_frame(mk(ActFrame, '1, 1'b1, '1, 1'b1, 1'b1));
        send_frame(mk(ActFrame, '1, 1'b1, 64'd0, 1'b0, 1'b1));
        send_frame(mk(ActFrame, StampMax, 1'b1, StampMax, 1'b1, 1'b0));
        send_frame(mk(ActAnchorReset, 64'd0, 1'b0, 64'd0, 1'b0, 1'b0));
        // delta limits exactly at half and three frames, then just below half
        send_frame(mk(ActFrame, 64'd0, 1'b1, 64'd0, 1'b1, 1'b1));
        send_frame(mk(ActFrame, f, 1'b1, f / 2, 1'b1, 1'b1));
        send_frame(mk(ActFrame, 2 * f, 1'b1, f / 2 + 3 * f, 1'b1, 1'b1));
        send_frame(mk(ActFrame, 3 * f, 1'b1, f / 2 + 3 * f + f / 2 - 1, 1'b1, 1'b1));
    endtask

    // random phase; the pressure variant holds the result side while sending back to back
    task automatic run_phase(input int n_items, input bit pressure);
        tl_rt      = {$urandom, $urandom} >> $urandom_range(40, 0);
        tl_pts     = {$urandom, $urandom} >> $urandom_range(40, 0);
        tx_no_gaps = pressure;
        if (pressure) hold_req = 1'b1;
        for (int i = 0; i < n_items; i++) begin
            if (i == n_items / 4) begin
                tl_rt  = StampMax - 64'(sb.frame_ns) * 64'($urandom_range(8, 0));
                tl_pts = StampMax - 64'(sb.frame_ns) * 64'($urandom_range(8, 0));
            end
            if (i == n_items / 2) begin
                // sender pause until the block is empty
                tx_no_gaps = 1'b0;
                s_tvalid <= 1'b0;
                wait_drained();
                tl_rt  = 64'($urandom);
                tl_pts = 64'($urandom);
            end
            send_frame(next_frame());
        end
        tx_no_gaps = 1'b0;
        s_tvalid <= 1'b0;
        wait_drained();
    endtask

    // main sequence
    initial begin
        bit [29:0] fd_list[6];
        fd_list[0] = 30'd1;
        fd_list[1] = 30'd1000000000;
        fd_list[2] = 30'd2;
        fd_list[3] = 30'd3;
        fd_list[4] = 30'($urandom_range(1000000000, 1));
        fd_list[5] = 30'($urandom_range(100, 1));
        cycle_count = 0;
        hold_req    = 1'b0;
        hold_left   = 0;
        run_left    = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();
        run_phase(PhaseItems, 1'b0);
        for (int k = 0; k < 6; k++) begin
            write_frame_ns(fd_list[k]);
            @(posedge aclk);
            run_phase(PhaseItems, k == 1);
        end

        if (sb.errors == 0 && sb.expected_stamps.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/vtr_pkg.sv
hw/rtl/vtr_front.sv
hw/rtl/vtr_queue.sv
hw/rtl/vtr_back.sv
hw/rtl/video_timestamp_retimer.sv
bench/tb.sv
